// File: hdl/fmrl_pkg.sv
// Shared types and constants for the first-match route lookup block.
// No dependencies; imported by fmrl_table, fmrl_ctrl, the top level and the testbench.
package fmrl_pkg;

  // Field widths fixed by the interface
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 8;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // Default number of table slots
  localparam int DEFAULT_TABLE_DEPTH = 64;

  // Request kinds
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // One stored route
  typedef struct packed {
    logic [ADDR_W-1:0] network;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  // Table write request (address travels separately, its width follows the depth)
  typedef struct packed {
    logic         en;
    route_entry_t data;
  } tbl_wr_t;

endpackage

// File: hdl/first_match_route_lookup_top.sv
// First-match route lookup, top level. A write word, or a lookup with n = 0 where
// n = min(entry_count, TABLE_DEPTH), goes from accept straight to the result state.
// Other lookups scan the table memory from slot 0, one read per cycle, and stop at the
// first match or after slot n - 1 on a miss. One word at a time, next accept in the
// cycle after the result loads into the output register. Reset (rst, synchronous)
// clears control state and entry_count; the table memory is not cleared.
module first_match_route_lookup_top
  import fmrl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [ADDR_W-1:0]  entry_network,
  input  logic [ADDR_W-1:0]  entry_mask,
  input  logic [ADDR_W-1:0]  entry_gateway,
  input  logic [PORT_W-1:0]  entry_port,
  input  logic [ADDR_W-1:0]  lookup_addr,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_done,
  output logic               hit,
  output logic [INDEX_W-1:0] match_index,
  output logic [ADDR_W-1:0]  gateway_addr,
  output logic [PORT_W-1:0]  out_port
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  tbl_wr_t      tbl_wr;
  logic [AW-1:0] tbl_wr_addr;
  logic         tbl_rd_en;
  logic [AW-1:0] tbl_rd_addr;
  route_entry_t tbl_rd_data;

  // sequencer
  fmrl_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .entry_index  (entry_index),
    .entry_network(entry_network),
    .entry_mask   (entry_mask),
    .entry_gateway(entry_gateway),
    .entry_port   (entry_port),
    .lookup_addr  (lookup_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_done   (write_done),
    .hit          (hit),
    .match_index  (match_index),
    .gateway_addr (gateway_addr),
    .out_port     (out_port),
    .tbl_wr       (tbl_wr),
    .tbl_wr_addr  (tbl_wr_addr),
    .tbl_rd_en    (tbl_rd_en),
    .tbl_rd_addr  (tbl_rd_addr),
    .tbl_rd_data  (tbl_rd_data)
  );

  // route table memory
  fmrl_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .wr_addr(tbl_wr_addr),
    .rd_en  (tbl_rd_en),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data)
  );

  // a write acknowledge never reports a hit
  a_write_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_done |-> !hit)
    else $error("write acknowledge carries a hit");

  // a miss carries zero index, gateway and port
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (match_index == '0) && (gateway_addr == '0) &&
                          (out_port == '0))
    else $error("miss word has nonzero fields");

  // one word at a time: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // no table write during a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    tbl_rd_en |-> !tbl_wr.en)
    else $error("table write overlaps a scan read");

endmodule

// File: hdl/fmrl_table.sv
// Route table storage: one synchronous memory, one write and one read port.
// Read data is registered. Depends on fmrl_pkg.
module fmrl_table
  import fmrl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic         clk,
  input  tbl_wr_t      wr,
  input  logic [AW-1:0] wr_addr,
  input  logic         rd_en,
  input  logic [AW-1:0] rd_addr,
  output route_entry_t rd_data
);

  route_entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/fmrl_ctrl.sv
// Request sequencer: table writes, first-match scan over the table memory,
// entry count register and the output word register. Depends on fmrl_pkg.
module fmrl_ctrl
  import fmrl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [ADDR_W-1:0]  entry_network,
  input  logic [ADDR_W-1:0]  entry_mask,
  input  logic [ADDR_W-1:0]  entry_gateway,
  input  logic [PORT_W-1:0]  entry_port,
  input  logic [ADDR_W-1:0]  lookup_addr,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_done,
  output logic               hit,
  output logic [INDEX_W-1:0] match_index,
  output logic [ADDR_W-1:0]  gateway_addr,
  output logic [PORT_W-1:0]  out_port,
  // table memory
  output tbl_wr_t            tbl_wr,
  output logic [AW-1:0]      tbl_wr_addr,
  output logic               tbl_rd_en,
  output logic [AW-1:0]      tbl_rd_addr,
  input  route_entry_t       tbl_rd_data
);

  // counter width holds 0..TABLE_DEPTH
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [COUNT_W-1:0] entry_count;
  logic [CW-1:0]      limit;
  logic [CW-1:0]      issue_ptr;
  logic [CW-1:0]      chk_idx;
  logic               chk_valid;
  logic [ADDR_W-1:0]  addr;

  // pending result, waits in RESP for the output register
  logic               res_write;
  logic               res_hit;
  logic [CW-1:0]      res_idx;
  logic [ADDR_W-1:0]  res_gateway;
  logic [PORT_W-1:0]  res_port;

  logic               accept;
  logic               is_write;
  logic [31:0]        slot_wide;
  logic               slot_ok;
  logic [LW-1:0]      count_wide;
  logic [LW-1:0]      depth_wide;
  logic [LW-1:0]      limit_wide;
  logic               match;
  logic               last_chk;
  logic               out_load;
  logic [31:0]        res_idx_wide;

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_write = (req_type == REQ_WRITE);

  // table write, taken straight from the accepted word
  assign slot_wide    = 32'(entry_index);
  assign slot_ok      = slot_wide < 32'(TABLE_DEPTH);
  assign tbl_wr.en    = accept && is_write && slot_ok;
  assign tbl_wr.data  = '{network: entry_network, mask: entry_mask,
                          gateway: entry_gateway, port: entry_port};
  assign tbl_wr_addr  = slot_wide[AW-1:0];

  // search limit saturates at the table depth
  assign count_wide = LW'(entry_count);
  assign depth_wide = LW'(TABLE_DEPTH);
  assign limit_wide = (count_wide > depth_wide) ? depth_wide : count_wide;

  // scan reads, one entry per cycle
  assign tbl_rd_en   = (state == ST_SCAN) && (issue_ptr < limit);
  assign tbl_rd_addr = issue_ptr[AW-1:0];

  // compare the entry returned by the memory
  assign match    = (tbl_rd_data.mask & tbl_rd_data.network) ==
                    (tbl_rd_data.mask & addr);
  assign last_chk = ({1'b0, chk_idx} + (CW+1)'(1)) == {1'b0, limit};

  assign out_load = (state == ST_RESP) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_write || (limit_wide == '0)) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chk_valid && (match || last_chk)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= tbl_rd_en && !(chk_valid && (match || last_chk));
    end
  end

  // scan pointers and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      addr        <= lookup_addr;
      limit       <= limit_wide[CW-1:0];
      issue_ptr   <= '0;
      res_write   <= is_write;
      res_hit     <= 1'b0;
      res_idx     <= '0;
      res_gateway <= '0;
      res_port    <= '0;
    end else if (state == ST_SCAN) begin
      if (tbl_rd_en) begin
        issue_ptr <= issue_ptr + CW'(1);
      end
      if (chk_valid && match) begin
        res_hit     <= 1'b1;
        res_idx     <= chk_idx;
        res_gateway <= tbl_rd_data.gateway;
        res_port    <= tbl_rd_data.port;
      end
    end
    if (tbl_rd_en) begin
      chk_idx <= issue_ptr;
    end
  end

  // output word register
  assign res_idx_wide = 32'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      write_done   <= res_write;
      hit          <= res_hit;
      match_index  <= res_idx_wide[INDEX_W-1:0];
      gateway_addr <= res_gateway;
      out_port     <= res_port;
    end
  end

endmodule

// File: verif/tb.sv
// Self-checking testbench for first_match_route_lookup_top: route table writes and
// first-match lookups, checked against an in-bench table predictor.
// Depends on fmrl_pkg and first_match_route_lookup_top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmrl_pkg::*;

  localparam int TBL_DEPTH    = DEFAULT_TABLE_DEPTH;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_WORDS  = 158;
  localparam int MAX_PRINTS   = 40;

  // One input word, fields in port order
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] slot;
    route_entry_t       ent;
    logic [ADDR_W-1:0]  addr;
  } route_req_t;

  // One result word, fields in port order
  typedef struct packed {
    logic               write_done;
    logic               hit;
    logic [INDEX_W-1:0] idx;
    logic [ADDR_W-1:0]  gw;
    logic [PORT_W-1:0]  port;
  } route_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = REQ_WRITE;
  logic [INDEX_W-1:0] entry_index = '0;
  logic [ADDR_W-1:0]  entry_network = '0;
  logic [ADDR_W-1:0]  entry_mask = '0;
  logic [ADDR_W-1:0]  entry_gateway = '0;
  logic [PORT_W-1:0]  entry_port = '0;
  logic [ADDR_W-1:0]  lookup_addr = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               write_done;
  logic               hit;
  logic [INDEX_W-1:0] match_index;
  logic [ADDR_W-1:0]  gateway_addr;
  logic [PORT_W-1:0]  out_port;

  first_match_route_lookup_top #(.TABLE_DEPTH(TBL_DEPTH)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .entry_index   (entry_index),
    .entry_network (entry_network),
    .entry_mask    (entry_mask),
    .entry_gateway (entry_gateway),
    .entry_port    (entry_port),
    .lookup_addr   (lookup_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_done    (write_done),
    .hit           (hit),
    .match_index   (match_index),
    .gateway_addr  (gateway_addr),
    .out_port      (out_port)
  );

  // Predictor state: route table and entry count as the block should hold them
  route_entry_t       fwd_tbl[TBL_DEPTH] = '{default: '0};
  logic [COUNT_W-1:0] fwd_count = '0;

  // Stimulus-side shadow, used to aim lookups and to keep scans on written slots
  route_entry_t plan_tbl[TBL_DEPTH];
  bit           plan_written[TBL_DEPTH];
  int           plan_count = 0;

  route_req_t route_reqs_pending[$];
  route_res_t due_routes[$];

  int  words_queued = 0;
  int  words_accepted = 0;
  int  results_seen = 0;
  int  n_writes = 0;
  int  n_lookups = 0;
  int  n_hits = 0;
  int  cfg_writes = 0;
  int  errs = 0;
  bit  in_took = 1'b0;
  int  send_gap = 0;
  bit  send_idle_on = 1'b1;
  bit  recv_idle_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_started = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  phase_counts[8] = '{64, 127, 0, 1, 65, 7, 0, 64};

  initial begin
    forever #1 clk = ~clk;
  end

  // Expected result of one word; writes also update the predicted table
  function automatic route_res_t route_predict(route_req_t w);
    route_res_t r;
    int lim;
    r = '0;
    if (w.kind == REQ_WRITE) begin
      if (int'(w.slot) < TBL_DEPTH) fwd_tbl[w.slot] = w.ent;
      r.write_done = 1'b1;
      return r;
    end
    // entry count saturates at the table depth
    lim = (int'(fwd_count) > TBL_DEPTH) ? TBL_DEPTH : int'(fwd_count);
    for (int k = 0; k < lim; k++) begin
      if ((fwd_tbl[k].mask & fwd_tbl[k].network) == (fwd_tbl[k].mask & w.addr)) begin
        r.hit  = 1'b1;
        r.idx  = INDEX_W'(k);
        r.gw   = fwd_tbl[k].gateway;
        r.port = fwd_tbl[k].port;
        return r;
      end
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Prefix masks of mostly long lengths, some short, some arbitrary bit patterns
  function automatic logic [ADDR_W-1:0] rand_mask();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom;
    len = (r < 15) ? $urandom_range(0, 7) : $urandom_range(8, 32);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Address inside slot j's network, host bits random
  function automatic logic [ADDR_W-1:0] aim_at(int j);
    return (plan_tbl[j].network & plan_tbl[j].mask) | ($urandom & ~plan_tbl[j].mask);
  endfunction

  task automatic note_mismatch(input string msg);
    errs++;
    if (errs <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_req(input route_req_t w);
    route_reqs_pending.push_back(w);
    words_queued++;
  endtask

  task automatic add_write(input int slot, input logic [ADDR_W-1:0] net,
                           input logic [ADDR_W-1:0] msk, input logic [ADDR_W-1:0] gw,
                           input logic [PORT_W-1:0] port);
    route_req_t w;
    w.kind = REQ_WRITE;
    w.slot = INDEX_W'(slot);
    w.ent  = '{network: net, mask: msk, gateway: gw, port: port};
    w.addr = $urandom;
    plan_tbl[slot] = w.ent;
    plan_written[slot] = 1'b1;
    push_req(w);
  endtask

  task automatic add_random_write();
    add_write($urandom_range(0, TBL_DEPTH - 1), $urandom, rand_mask(), $urandom,
              PORT_W'($urandom_range(0, 255)));
  endtask

  // Lookups are only issued when every slot in the scan range holds a route
  task automatic add_lookup(input logic [ADDR_W-1:0] a);
    route_req_t w;
    int lim;
    lim = (plan_count > TBL_DEPTH) ? TBL_DEPTH : plan_count;
    for (int k = 0; k < lim; k++) if (!plan_written[k]) return;
    w.kind = REQ_LOOKUP;
    w.slot = INDEX_W'($urandom_range(0, TBL_DEPTH - 1));
    w.ent  = '{network: $urandom, mask: $urandom, gateway: $urandom,
               port: PORT_W'($urandom_range(0, 255))};
    w.addr = a;
    push_req(w);
  endtask

  // Wait until every word is in and every result is out
  task automatic drain_block(input int extra);
    while (words_accepted != words_queued || due_routes.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Entry count is only changed while the block is idle
  task automatic set_entry_count(input int n);
    drain_block(4);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(n);
    fwd_count   = COUNT_W'(n);
    plan_count  = n;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sender: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin : drv
    route_req_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (route_reqs_pending.size() > 0) begin
        w = route_reqs_pending.pop_front();
        {req_type, entry_index, entry_network, entry_mask, entry_gateway, entry_port,
         lookup_addr} <= w;
        in_valid <= 1'b1;
        send_gap = send_idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold while the sender keeps offering
  always @(negedge clk) begin : rcv
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted words
  always @(posedge clk) begin : mon
    route_res_t got;
    route_res_t want;
    route_req_t taken;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {write_done, hit, match_index, gateway_addr, out_port};
        results_seen++;
        if (due_routes.size() == 0) begin
          note_mismatch($sformatf("result with nothing due: %p", got));
        end else begin
          want = due_routes.pop_front();
          check_field("write_done", got.write_done, want.write_done);
          check_field("hit", got.hit, want.hit);
          check_field("match_index", got.idx, want.idx);
          check_field("gateway_addr", got.gw, want.gw);
          check_field("out_port", got.port, want.port);
        end
      end
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        taken = {req_type, entry_index, entry_network, entry_mask, entry_gateway, entry_port,
                 lookup_addr};
        want = route_predict(taken);
        due_routes.push_back(want);
        words_accepted++;
        if (taken.kind == REQ_WRITE) n_writes++;
        else n_lookups++;
        if (want.hit) n_hits++;
      end
    end
  end

  // Stimulus
  initial begin
    int cnt;
    int lim;
    int r;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero entry count: everything misses
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);

    // Host route, /8, /16, default route, and the last slot
    add_write(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    add_write(1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 8'h01);
    add_write(2, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 8'h02);
    add_write(3, 32'h0000_0000, 32'h0000_0000, 32'h0102_0304, 8'h00);
    add_write(TBL_DEPTH - 1, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 32'h0000_0000, 8'h80);

    // One slot searched: later matches are out of range
    set_entry_count(1);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0000_0000);
    add_lookup(32'h0A01_0203);

    // Four slots: each route wins in turn, default route catches the rest
    set_entry_count(4);
    add_lookup(32'hFFFF_FFFF);
    add_lookup(32'h0A7F_0001);
    add_lookup(32'hC0A8_FFFF);
    add_lookup(32'h1234_5678);
    add_lookup(32'h0000_0000);

    // Overwrite slot 0 with an all-zero host route
    add_write(0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
    add_lookup(32'h0000_0000);
    add_lookup(32'hFFFF_FFFF);

    // Load the whole table
    for (int s = 0; s < TBL_DEPTH; s++)
      add_write(s, $urandom, rand_mask(), $urandom, PORT_W'($urandom_range(0, 255)));

    // Random phases, one entry count each
    for (int p = 0; p < 8; p++) begin
      cnt = (p == 6) ? $urandom_range(2, 126) : phase_counts[p];
      set_entry_count(cnt);
      send_idle_on = (p % 3 != 0);
      recv_idle_on = (p % 4 != 1);
      if (p == 1) hold_req = 1'b1;
      lim = (cnt > TBL_DEPTH) ? TBL_DEPTH : cnt;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 25) add_random_write();
        else if (r < 80 && lim > 0) add_lookup(aim_at($urandom_range(0, lim - 1)));
        else add_lookup($urandom);
      end
    end

    drain_block(DRAIN_CYCLES);
    $display("tb: %0d table writes, %0d lookups (%0d hits, %0d misses), %0d results checked",
             n_writes, n_lookups, n_hits, n_lookups - n_hits, results_seen);
    $display("tb: %0d entry count settings from 0 to 127, one %0d-cycle output hold",
             cfg_writes, HOLD_CYCLES);
    if (errs == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Hard limit, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
hdl/fmrl_pkg.sv
hdl/fmrl_table.sv
hdl/fmrl_ctrl.sv
hdl/first_match_route_lookup_top.sv
verif/tb.sv
